FILE: design/lfc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the largest free circle core.
// No dependencies.
package lfc_pkg;
	localparam int GRID_MAX   = 64;
	localparam int COORD_W    = 6;              // row / column index width
	localparam int SIDE_W     = 7;              // grid_size register width
	localparam int ADDR_W     = 2 * COORD_W;    // cell store address
	localparam int DIST_W     = 13;             // squared distance, up to 2*63^2
	localparam int RADIUS_W   = 5;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CEN_A,
		ST_CEN_D,
		ST_SCAN_A,
		ST_SCAN_D,
		ST_RAD,
		ST_NEXT,
		ST_OUT
	} lfc_state_t;
endpackage

FILE: design/largest_free_circle_in_grid_core.sv
`timescale 1ns / 1ps
// Largest free circle in a square binary grid: top level.
// Depends on lfc_pkg, lfc_grid_mem, lfc_dist_unit.
//
// Usage:
//  - s_tdata[0] carries one cell (1 = obstacle) per transaction, row-major.
//    Cells load one per cycle while s_tready is high.
//  - After the n*n-th cell, s_tready drops and a sequencer walks the stored
//    grid: for each free center it scans the fitting square, tracks the
//    nearest obstacle distance squared, then steps the radius up.
//    Per center: a center read, then a scan of the (2f+1)^2 cells of the square
//    (f = distance to the nearest edge), each cell read and then checked, then
//    a radius step up to r (r = radius found, at most f), then an advance.
//    A blocked center skips the scan and the radius step. The scan uses the one
//    memory port; the scan and the radius step share the one squaring unit.
//  - The result (m_tdata[4:0] = max_radius) is held with m_tvalid until
//    m_tready; only then is the next grid accepted.
//  - cfg_we writes grid_size (0 acts as 1, above 64 acts as 64) and restarts
//    the cell count. Write only while idle.
//  - Reset (arst_n low) returns to loading with grid_size 64 and count 0;
//    the cell store is not cleared, every cell is written before use.
module largest_free_circle_in_grid_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,    // grid_size
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // [0] blocked, [7:1] zero
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata      // [4:0] max_radius, [7:5] zero
);
	localparam int CW = lfc_pkg::COORD_W;

	lfc_pkg::lfc_state_t state_q, state_d;

	logic [lfc_pkg::SIDE_W-1:0] grid_size_q;
	logic [lfc_pkg::SIDE_W-1:0] side;
	logic [CW-1:0]              last;       // n-1
	logic [CW-1:0]              row_q, col_q;
	logic [CW-1:0]              p_q, q_q, i_q, j_q, fit_q, r_q, best_q;
	logic [lfc_pkg::DIST_W-1:0] dmin_q;

	logic                       mem_we, mem_rdata;
	logic [lfc_pkg::ADDR_W-1:0] mem_addr;
	logic [CW-1:0]              du_a, du_b;
	logic [lfc_pkg::DIST_W-1:0] du_sq;
	logic [CW-1:0]              fit_c, lo_p, lo_q, f1, f2;
	logic                       load_acc;

	// clamp grid size to 1..GRID_MAX
	always_comb begin
		if (grid_size_q == '0) begin
			side = lfc_pkg::SIDE_W'(1);
		end else if (grid_size_q > lfc_pkg::SIDE_W'(lfc_pkg::GRID_MAX)) begin
			side = lfc_pkg::SIDE_W'(lfc_pkg::GRID_MAX);
		end else begin
			side = grid_size_q;
		end
		last = CW'(side - lfc_pkg::SIDE_W'(1));
	end

	// distance from center to nearest grid edge
	always_comb begin
		lo_p  = (p_q < q_q) ? p_q : q_q;
		f1    = last - p_q;
		f2    = last - q_q;
		fit_c = lo_p;
		if (f1 < fit_c) begin
			fit_c = f1;
		end
		if (f2 < fit_c) begin
			fit_c = f2;
		end
		lo_q  = '0;
	end

	assign load_acc = s_tvalid && s_tready;

	// shared squaring unit: scan distance or (r+1)^2
	always_comb begin
		if (state_q == lfc_pkg::ST_RAD) begin
			du_a = r_q + CW'(1);
			du_b = lo_q;
		end else begin
			du_a = (i_q > p_q) ? i_q - p_q : p_q - i_q;
			du_b = (j_q > q_q) ? j_q - q_q : q_q - j_q;
		end
	end

	lfc_dist_unit u_dist (
		.a      (du_a),
		.b      (du_b),
		.sum_sq (du_sq)
	);

	always_comb begin
		mem_we = 1'b0;
		case (state_q)
			lfc_pkg::ST_LOAD: begin
				mem_addr = {row_q, col_q};
				mem_we   = load_acc;
			end
			lfc_pkg::ST_CEN_A: mem_addr = {p_q, q_q};
			default:           mem_addr = {i_q, j_q};
		endcase
	end

	lfc_grid_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (s_tdata[0]),
		.rdata (mem_rdata)
	);

	// next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			lfc_pkg::ST_LOAD: begin
				s_tready = 1'b1;
				if (load_acc && col_q == last && row_q == last) begin
					state_d = lfc_pkg::ST_CEN_A;
				end
			end
			lfc_pkg::ST_CEN_A: state_d = lfc_pkg::ST_CEN_D;
			lfc_pkg::ST_CEN_D: begin
				state_d = mem_rdata ? lfc_pkg::ST_NEXT : lfc_pkg::ST_SCAN_A;
			end
			lfc_pkg::ST_SCAN_A: state_d = lfc_pkg::ST_SCAN_D;
			lfc_pkg::ST_SCAN_D: begin
				if (j_q == q_q + fit_q && i_q == p_q + fit_q) begin
					state_d = lfc_pkg::ST_RAD;
				end else begin
					state_d = lfc_pkg::ST_SCAN_A;
				end
			end
			lfc_pkg::ST_RAD: begin
				if (!(r_q < fit_q && du_sq < dmin_q)) begin
					state_d = lfc_pkg::ST_NEXT;
				end
			end
			lfc_pkg::ST_NEXT: begin
				state_d = (q_q == last && p_q == last) ? lfc_pkg::ST_OUT
				                                       : lfc_pkg::ST_CEN_A;
			end
			lfc_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = lfc_pkg::ST_LOAD;
				end
			end
			default: state_d = lfc_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfc_pkg::ST_LOAD;
			grid_size_q <= lfc_pkg::SIDE_W'(lfc_pkg::GRID_MAX);
			row_q       <= '0;
			col_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				grid_size_q <= cfg_data;
				row_q       <= '0;
				col_q       <= '0;
			end else if (load_acc) begin
				if (col_q == last) begin
					col_q <= '0;
					row_q <= (row_q == last) ? '0 : row_q + CW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lfc_pkg::ST_LOAD: begin
				p_q    <= '0;
				q_q    <= '0;
				best_q <= '0;
			end
			lfc_pkg::ST_CEN_D: begin
				fit_q  <= fit_c;
				i_q    <= p_q - fit_c;
				j_q    <= q_q - fit_c;
				dmin_q <= '1;
			end
			lfc_pkg::ST_SCAN_D: begin
				if (mem_rdata && du_sq < dmin_q) begin
					dmin_q <= du_sq;
				end
				if (j_q == q_q + fit_q) begin
					j_q <= q_q - fit_q;
					i_q <= i_q + CW'(1);
				end else begin
					j_q <= j_q + CW'(1);
				end
				r_q <= '0;
			end
			lfc_pkg::ST_RAD: begin
				if (r_q < fit_q && du_sq < dmin_q) begin
					r_q <= r_q + CW'(1);
				end else if (r_q > best_q) begin
					best_q <= r_q;
				end
			end
			lfc_pkg::ST_NEXT: begin
				if (q_q == last) begin
					q_q <= '0;
					p_q <= p_q + CW'(1);
				end else begin
					q_q <= q_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = {3'b000, best_q[lfc_pkg::RADIUS_W-1:0]};
endmodule

FILE: design/lfc_grid_mem.sv
`timescale 1ns / 1ps
// Single-port 4096 x 1 cell store with registered read data.
// Depends on lfc_pkg.
module lfc_grid_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [lfc_pkg::ADDR_W-1:0] addr,
	input  logic                       wdata,
	output logic                       rdata
);
	logic mem [0:(1 << lfc_pkg::ADDR_W)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: design/lfc_dist_unit.sv
`timescale 1ns / 1ps
// Shared squaring unit: a*a + b*b on narrow operands.
// Depends on lfc_pkg.
module lfc_dist_unit (
	input  logic [lfc_pkg::COORD_W-1:0] a,
	input  logic [lfc_pkg::COORD_W-1:0] b,
	output logic [lfc_pkg::DIST_W-1:0]  sum_sq
);
	logic [2*lfc_pkg::COORD_W-1:0] a_sq;
	logic [2*lfc_pkg::COORD_W-1:0] b_sq;

	always_comb begin
		a_sq   = a * a;
		b_sq   = b * b;
		sum_sq = {1'b0, a_sq} + {1'b0, b_sq};
	end
endmodule

FILE: verif/lfc_checker.sv
`timescale 1ns / 1ps
// Checker for largest_free_circle_in_grid_core: tracks grid_size, stores cells,
// predicts max_radius per grid and compares it with the result channel. Uses lfc_pkg.
module lfc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	output int         errors,
	output int         pending
);
	bit                          grid_cells [0:lfc_pkg::GRID_MAX*lfc_pkg::GRID_MAX-1];
	int                          side_reg;
	int                          cells_in;
	logic [lfc_pkg::RADIUS_W-1:0] radius_q[$];

	function automatic int side_eff(int v);
		if (v < 1) return 1;
		if (v > lfc_pkg::GRID_MAX) return lfc_pkg::GRID_MAX;
		return v;
	endfunction

	// Best radius over all free centers; full disk check, squared distances.
	function automatic logic [lfc_pkg::RADIUS_W-1:0] best_radius(int n);
		int best, fit, nearest, r, d2;
		best = 0;
		for (int p = 0; p < n; p++)
			for (int q = 0; q < n; q++) begin
				if (grid_cells[p*n+q]) continue;
				fit = p;
				if (q < fit) fit = q;
				if (n-1-p < fit) fit = n-1-p;
				if (n-1-q < fit) fit = n-1-q;
				nearest = 32'h7fffffff;
				for (int i = p - fit; i <= p + fit; i++)
					for (int j = q - fit; j <= q + fit; j++) begin
						d2 = (i-p)*(i-p) + (j-q)*(j-q);
						if (grid_cells[i*n+j] && d2 < nearest) nearest = d2;
					end
				r = 0;
				while (r < fit && (r+1)*(r+1) < nearest) r++;
				if (r > best) best = r;
			end
		if (best > 31) best = 31;
		return best[lfc_pkg::RADIUS_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int n;
		logic [lfc_pkg::RADIUS_W-1:0] want;
		if (!arst_n) begin
			side_reg = lfc_pkg::GRID_MAX;
			cells_in = 0;
			radius_q.delete();
			errors   = 0;
			pending  = 0;
		end else begin
			if (cfg_we) begin
				side_reg = int'(cfg_data);
				cells_in = 0;
			end else if (s_tvalid && s_tready) begin
				n = side_eff(side_reg);
				grid_cells[cells_in] = s_tdata[0];
				cells_in++;
				if (cells_in == n*n) begin
					radius_q.insert(radius_q.size(), best_radius(n));
					cells_in = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				if (radius_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transaction: max_radius %0d", m_tdata[4:0]);
				end else begin
					want = radius_q.pop_front();
					if (m_tdata[4:0] !== want || m_tdata[7:5] !== 3'b0) begin
						errors++;
						if (errors <= 10)
							$display("max_radius mismatch: expected %0d, got %0d (tdata %h)",
								want, m_tdata[4:0], m_tdata);
					end
				end
			end
			pending = radius_q.size();
		end
	end
endmodule

FILE: verif/tb_largest_free_circle_in_grid_core.sv
`timescale 1ns / 1ps
// Testbench top for largest_free_circle_in_grid_core: drives grids of cells,
// random handshake idling and grid_size writes; lfc_checker does the checking.
module tb_largest_free_circle_in_grid_core;
	localparam int STALL_LIMIT = 2000000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_data;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	int         errors, pending;
	int         src_idle, snk_idle;
	int         stall_cycles;
	int         cells_sent;

	largest_free_circle_in_grid_core uut (.*);

	lfc_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result side: random backpressure
	always @(posedge clk) m_tready <= ($urandom_range(99) >= snk_idle);

	// no transaction on either side for too long: give up
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_cell(input bit blk);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, blk};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		cells_sent++;
	endtask

	// wait for all results, then idle so the block is back to loading
	task automatic drain();
		@(posedge clk);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_size(input logic [6:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		@(posedge clk);
	endtask

	// full grid: obstacle probability in percent
	task automatic send_grid(input int n, input int pct);
		for (int k = 0; k < n*n; k++) send_cell($urandom_range(99) < pct);
	endtask

	initial begin
		int n, pct;
		arst_n = 0; cfg_we = 0; cfg_data = 0;
		s_tvalid = 0; s_tdata = 0; m_tready = 0;
		stall_cycles = 0; cells_sent = 0;
		src_idle = 25; snk_idle = 45;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// size 0 acts as 1
		write_size(7'd0); send_cell(0); send_cell(1); drain();
		write_size(7'd1); send_cell(0); send_cell(1); drain();
		write_size(7'd3); send_grid(3, 0); drain();
		write_size(7'd5); send_grid(5, 0); drain();
		// corner obstacle in an all-free 7x7 grid
		write_size(7'd7); send_cell(1); for (int k = 1; k < 49; k++) send_cell(0); drain();

		// random grids, three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 25 : (ph == 1) ? 45 : 0;
			snk_idle = (ph == 0) ? 45 : (ph == 1) ? 25 : 0;
			cells_sent = 0;
			while (cells_sent < 230) begin
				n = ($urandom_range(15) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 9);
				case ($urandom_range(4))
					0: pct = 0;
					1: pct = 5;
					2: pct = 20;
					3: pct = 50;
					default: pct = 100;
				endcase
				write_size((n == 1 && $urandom_range(1)) ? 7'd0 : 7'(n));
				send_grid(n, pct);
				drain();
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
